### hdl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
`timescale 1ns / 1ps

package wpm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CLOS_LVLS   = $clog2(POS_W);

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    typedef struct packed {
        logic       fire;
        op_t        op;
        logic [7:0] data;
    } step_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

endpackage

### hdl/wpm_engine.sv
// Pattern store and bit-parallel position set with star closure.
`timescale 1ns / 1ps

module wpm_engine
    import wpm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  step_t    step,
    output verdict_t verdict
);

    logic [7:0]       pat_byte_reg [PATTERN_MAX];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] active_reg, active_next;
    logic             ovf_reg, ovf_next;

    logic [PATTERN_MAX-1:0] pos_valid;
    logic [PATTERN_MAX-1:0] pos_star;
    logic [PATTERN_MAX-1:0] pos_hit;
    logic [POS_W-1:0]       closed;
    logic [POS_W-1:0]       advanced;

    // Prefix OR along runs of stars: bit j is set if some set bit i <= j
    // is followed only by stars up to j. Log-depth, like a carry lookahead.
    function automatic logic [POS_W-1:0] star_closure(
        input logic [POS_W-1:0]       set,
        input logic [PATTERN_MAX-1:0] star
    );
        logic [POS_W-1:0] g, p, g_n, p_n;
        int               d;
        g = set;
        p = {star, 1'b0};
        for (int lvl = 0; lvl < CLOS_LVLS; lvl++) begin
            d   = 1 << lvl;
            g_n = g;
            p_n = p;
            for (int j = 0; j < POS_W; j++) begin
                if (j >= d) begin
                    g_n[j] = g[j] | (p[j] & g[j-d]);
                    p_n[j] = p[j] & p[j-d];
                end
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pos_valid[i] = (CNT_W'(i) < count_reg);
            pos_star[i]  = pos_valid[i] && (pat_byte_reg[i] == STAR_BYTE);
            pos_hit[i]   = pos_valid[i] && !pos_star[i] &&
                           ((pat_byte_reg[i] == ANY_BYTE) || (pat_byte_reg[i] == step.data));
        end
        closed   = star_closure(active_reg, pos_star);
        advanced = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            advanced[i]   = advanced[i] | (closed[i] & pos_star[i]);
            advanced[i+1] = closed[i] & pos_hit[i];
        end
    end

    assign verdict.matched  = (count_reg != '0) && !ovf_reg && closed[count_reg];
    assign verdict.overflow = ovf_reg;

    always_comb begin
        count_next  = count_reg;
        active_next = active_reg;
        ovf_next    = ovf_reg;
        if (step.fire) begin
            case (step.op)
                OP_CLEAR: begin
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    active_next = POS_W'(1);
                end
                OP_APPEND: begin
                    if (count_reg < CNT_W'(PATTERN_MAX)) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    active_next = POS_W'(1);
                end
                OP_TEXT: begin
                    active_next = advanced;
                end
                OP_END: begin
                    active_next = POS_W'(1);
                end
                default: begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            active_reg <= POS_W'(1);
            ovf_reg    <= 1'b0;
        end else begin
            count_reg  <= count_next;
            active_reg <= active_next;
            ovf_reg    <= ovf_next;
        end
    end

    // Pattern bytes: written at the fill pointer, no reset needed.
    always_ff @(posedge aclk) begin
        if (step.fire && (step.op == OP_APPEND) &&
            (count_reg < CNT_W'(PATTERN_MAX))) begin
            pat_byte_reg[count_reg[IDX_W-1:0]] <= step.data;
        end
    end

endmodule

### hdl/wildcard_pattern_matcher_unit.sv
// Top level of the glob wildcard pattern matcher.
`timescale 1ns / 1ps

// Glob matcher: '*' matches any run of bytes (also empty), '?' any one byte,
// any other pattern byte only itself. Whole-text match only.
//
// Input stream (s_): one transfer per command, kind in s_tuser:
//   clear pattern, append pattern byte, text byte, end of text.
//   s_tdata carries the pattern or text byte.
// Result stream (m_): one transfer per end-of-text command, carrying
//   matched and pattern_overflow. Other commands give no result.
// Pattern store holds 32 bytes; further appends set the overflow flag,
// which forces matched low until the next clear. Empty pattern never matches.
// Appending a byte or ending a text restarts text evaluation.
// Throughput: one command per cycle unless a result is stalled; the position
//   update (byte compare across all positions plus log-depth star closure) is combinational.
// Latency: the result is valid the cycle after the end-of-text transfer.
// Stall: the result sits in an output register; s_tready stays high while
//   that register is empty or is being drained, so input keeps flowing.
// Reset (aresetn low, synchronous): pattern empty, overflow clear,
//   no result pending.

module wildcard_pattern_matcher_unit
    import wpm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    step_t    step;
    verdict_t verdict;

    logic     m_tvalid_reg, m_tvalid_next;
    verdict_t result_reg;
    logic     s_accept;

    // Ready unless a result is stuck in the output register.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign step.fire = s_accept;
    assign step.op   = op_t'(s_tuser);
    assign step.data = s_tdata;

    wpm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .verdict (verdict)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept && (step.op == OP_END)) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Verdict captured on the end-of-text transfer.
    always_ff @(posedge aclk) begin
        if (s_accept && (step.op == OP_END)) begin
            result_reg <= verdict;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, result_reg.overflow, result_reg.matched};

endmodule

### hdl/wpm_checker.sv
// Port-level checks for the wildcard pattern matcher, bound to the top level.
`timescale 1ns / 1ps

module wpm_checker
    import wpm_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic end_xfer, clear_xfer;
    assign end_xfer   = s_tvalid && s_tready && (s_tuser == OP_END);
    assign clear_xfer = s_tvalid && s_tready && (s_tuser == OP_CLEAR);

    // Held result must not change while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every end-of-text transfer yields a result next cycle.
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        end_xfer |=> m_tvalid)
        else $error("no result after end of text");

    // Overflow forces a no-match verdict.
    a_ovf_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("match reported with pattern overflow");

    // Empty pattern right after clear never matches and shows no overflow.
    a_empty_pat: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_xfer ##1 end_xfer |=> (m_tdata[1:0] == 2'b00))
        else $error("empty pattern gave match or overflow");

    // Input only back-pressured by a stalled result.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

endmodule

bind wildcard_pattern_matcher_unit wpm_checker u_wpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
